FILE: rtl/core/ppfi_pkg.sv
`timescale 1ns / 1ps

package ppfi_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DROP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUP          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REORDER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORRUPT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MILLIS = 3'd5;

  localparam int unsigned NUM_INTERVALS = 5;

  // Field widths
  localparam int unsigned INTERVAL_W = 32;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned TAIL_W     = 8;

  localparam logic [DELAY_W-1:0] MAX_DELAY_MILLIS   = 16'd60000;
  localparam logic [DELAY_W-1:0] DELAY_MILLIS_RESET = 16'd1;
  localparam logic [TAIL_W-1:0]  TAIL_FLIP          = 8'h01;

  // Input action and result kind codes
  localparam logic ACTION_PROCESS = 1'b0;
  localparam logic ACTION_FLUSH   = 1'b1;
  localparam logic KIND_PACKET    = 1'b0;
  localparam logic KIND_DROP      = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

endpackage

FILE: rtl/core/periodic_packet_fault_injector.sv
// A packet word runs, after acceptance, the five interval checks as serial remainder
//   steps on the single shared restoring remainder unit, one bit a cycle; its first
//   result is registered after the last step. No new word is accepted until the word
//   is finished and its output, if any, is taken.
// A flush word releases the held packet, if any, in the cycle after acceptance.
// Reset (async, active low) empties the held slot and output, intervals to 0, delay to 1 ms.
`timescale 1ns / 1ps

module periodic_packet_fault_injector
  import ppfi_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned SEQ_BITS    = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [SEQ_BITS-1:0]    seq_num_i,
  input  logic [HANDLE_BITS-1:0] pkt_handle_i,
  input  logic [TAIL_W-1:0]      tail_byte_i,
  input  logic                   nonempty_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   kind_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic [TAIL_W-1:0]      out_tail_byte_o,
  output logic                   out_nonempty_o,
  output logic                   dup_flag_o,
  output logic                   corrupt_flag_o,
  output logic [DELAY_W-1:0]     delay_out_o,
  output logic                   reorder_mark_o,
  output logic                   last_o
);

  localparam int unsigned CNT_W = $clog2(SEQ_BITS);
  localparam int unsigned IDX_W = $clog2(NUM_INTERVALS);

  // Configuration registers
  logic [INTERVAL_W-1:0] ival_q [NUM_INTERVALS];
  logic [DELAY_W-1:0]    dly_millis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_INTERVALS; i++) begin
        ival_q[i] <= '0;
      end
      dly_millis_q <= DELAY_MILLIS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DELAY_MILLIS) begin
        dly_millis_q <= cfg_wdata_i[DELAY_W-1:0];
      end else if (cfg_idx_i < REG_DELAY_MILLIS) begin
        ival_q[cfg_idx_i[IDX_W-1:0]] <= cfg_wdata_i[INTERVAL_W-1:0];
      end
    end
  end

  // Control state
  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [NUM_INTERVALS-1:0] hit_q, hit_d;
  logic                     held_valid_q, held_valid_d;
  logic                     second_q, second_d;
  logic                     ov_q, ov_d;

  // Payload registers
  logic [SEQ_BITS-1:0]    seq_q, seq_d;
  logic [SEQ_BITS-1:0]    sh_q, sh_d;
  logic [INTERVAL_W-1:0]  rem_q, rem_d;
  logic [HANDLE_BITS-1:0] hnd_q, hnd_d;
  logic [TAIL_W-1:0]      tail_q, tail_d;
  logic                   ne_q, ne_d;

  logic [HANDLE_BITS-1:0] h_handle_q, h_handle_d;
  logic [TAIL_W-1:0]      h_tail_q, h_tail_d;
  logic                   h_ne_q, h_ne_d;
  logic                   h_dup_q, h_dup_d;
  logic                   h_cor_q, h_cor_d;
  logic [DELAY_W-1:0]     h_delay_q, h_delay_d;

  logic                   okind_q, okind_d;
  logic [HANDLE_BITS-1:0] ohnd_q, ohnd_d;
  logic [TAIL_W-1:0]      otail_q, otail_d;
  logic                   one_q, one_d;
  logic                   odup_q, odup_d;
  logic                   ocor_q, ocor_d;
  logic [DELAY_W-1:0]     odelay_q, odelay_d;
  logic                   omark_q, omark_d;
  logic                   olast_q, olast_d;

  // Shared remainder unit: one restoring step per cycle
  logic [INTERVAL_W-1:0] ival;
  logic [INTERVAL_W:0]   rem_sh;
  logic [INTERVAL_W:0]   rem_sub;
  logic [INTERVAL_W-1:0] rem_step;
  logic                  hit_now;

  assign ival     = ival_q[idx_q];
  assign rem_sh   = {rem_q, sh_q[SEQ_BITS-1]};
  assign rem_sub  = rem_sh - {1'b0, ival};
  assign rem_step = (rem_sh >= {1'b0, ival}) ? rem_sub[INTERVAL_W-1:0]
                                              : rem_sh[INTERVAL_W-1:0];
  assign hit_now  = (ival != '0) && (rem_step == '0);

  logic in_acc, out_acc, last_step;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = ov_q && !out_stall_i;
  assign last_step = (cnt_q == CNT_W'(SEQ_BITS - 1));

  // Packet result after all checks
  logic [NUM_INTERVALS-1:0] hits_all;
  logic [TAIL_W-1:0]        c_tail;
  logic [DELAY_W-1:0]       c_delay;
  logic [DELAY_W-1:0]       delay_sat;

  always_comb begin
    hits_all = hit_q;
    hits_all[IDX_W'(REG_DELAY)] = hit_now;
    delay_sat = (dly_millis_q > MAX_DELAY_MILLIS) ? MAX_DELAY_MILLIS : dly_millis_q;
    if (!ne_q) begin
      c_tail = '0;
    end else if (hits_all[IDX_W'(REG_CORRUPT)]) begin
      c_tail = tail_q ^ TAIL_FLIP;
    end else begin
      c_tail = tail_q;
    end
    c_delay = hits_all[IDX_W'(REG_DELAY)] ? delay_sat : '0;
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    held_valid_d = held_valid_q;
    second_d     = second_q;
    ov_d         = ov_q;
    seq_d        = seq_q;
    sh_d         = sh_q;
    rem_d        = rem_q;
    hnd_d        = hnd_q;
    tail_d       = tail_q;
    ne_d         = ne_q;
    h_handle_d   = h_handle_q;
    h_tail_d     = h_tail_q;
    h_ne_d       = h_ne_q;
    h_dup_d      = h_dup_q;
    h_cor_d      = h_cor_q;
    h_delay_d    = h_delay_q;
    okind_d      = okind_q;
    ohnd_d       = ohnd_q;
    otail_d      = otail_q;
    one_d        = one_q;
    odup_d       = odup_q;
    ocor_d       = ocor_q;
    odelay_d     = odelay_q;
    omark_d      = omark_q;
    olast_d      = olast_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ACTION_FLUSH) begin
            // release the held packet, if any
            if (held_valid_q) begin
              okind_d      = KIND_PACKET;
              ohnd_d       = h_handle_q;
              otail_d      = h_tail_q;
              one_d        = h_ne_q;
              odup_d       = h_dup_q;
              ocor_d       = h_cor_q;
              odelay_d     = h_delay_q;
              omark_d      = 1'b0;
              olast_d      = 1'b1;
              ov_d         = 1'b1;
              second_d     = 1'b0;
              held_valid_d = 1'b0;
              state_d      = ST_OUT;
            end
          end else begin
            seq_d   = seq_num_i;
            sh_d    = seq_num_i;
            rem_d   = '0;
            hnd_d   = pkt_handle_i;
            tail_d  = tail_byte_i;
            ne_d    = nonempty_i;
            idx_d   = '0;
            cnt_d   = '0;
            state_d = ST_CALC;
          end
        end
      end

      ST_CALC: begin
        sh_d  = {sh_q[SEQ_BITS-2:0], 1'b0};
        rem_d = rem_step;
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          hit_d[idx_q] = hit_now;
          sh_d  = seq_q;
          rem_d = '0;
          cnt_d = '0;
          idx_d = idx_q + 1'b1;
          if (idx_q == IDX_W'(REG_DELAY)) begin
            state_d  = ST_IDLE;
            second_d = 1'b0;
            okind_d  = KIND_PACKET;
            ohnd_d   = hnd_q;
            otail_d  = c_tail;
            one_d    = ne_q;
            odup_d   = hits_all[IDX_W'(REG_DUP)];
            ocor_d   = hits_all[IDX_W'(REG_CORRUPT)];
            odelay_d = c_delay;
            omark_d  = 1'b0;
            olast_d  = 1'b1;
            priority if (hits_all[IDX_W'(REG_DROP)]) begin
              // drop notice, held packet untouched
              okind_d  = KIND_DROP;
              otail_d  = '0;
              one_d    = 1'b0;
              odup_d   = 1'b0;
              ocor_d   = 1'b0;
              odelay_d = '0;
              ov_d     = 1'b1;
              state_d  = ST_OUT;
            end else if (held_valid_q) begin
              // current first, then the held one
              omark_d  = 1'b1;
              olast_d  = 1'b0;
              second_d = 1'b1;
              ov_d     = 1'b1;
              state_d  = ST_OUT;
            end else if (hits_all[IDX_W'(REG_REORDER)]) begin
              held_valid_d = 1'b1;
              h_handle_d   = hnd_q;
              h_tail_d     = c_tail;
              h_ne_d       = ne_q;
              h_dup_d      = hits_all[IDX_W'(REG_DUP)];
              h_cor_d      = hits_all[IDX_W'(REG_CORRUPT)];
              h_delay_d    = c_delay;
            end else begin
              ov_d    = 1'b1;
              state_d = ST_OUT;
            end
          end
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          if (second_q) begin
            okind_d      = KIND_PACKET;
            ohnd_d       = h_handle_q;
            otail_d      = h_tail_q;
            one_d        = h_ne_q;
            odup_d       = h_dup_q;
            ocor_d       = h_cor_q;
            odelay_d     = h_delay_q;
            omark_d      = 1'b0;
            olast_d      = 1'b1;
            second_d     = 1'b0;
            held_valid_d = 1'b0;
          end else begin
            ov_d    = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
        ov_d    = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      hit_q        <= '0;
      held_valid_q <= 1'b0;
      second_q     <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      hit_q        <= hit_d;
      held_valid_q <= held_valid_d;
      second_q     <= second_d;
      ov_q         <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    sh_q       <= sh_d;
    rem_q      <= rem_d;
    hnd_q      <= hnd_d;
    tail_q     <= tail_d;
    ne_q       <= ne_d;
    h_handle_q <= h_handle_d;
    h_tail_q   <= h_tail_d;
    h_ne_q     <= h_ne_d;
    h_dup_q    <= h_dup_d;
    h_cor_q    <= h_cor_d;
    h_delay_q  <= h_delay_d;
    okind_q    <= okind_d;
    ohnd_q     <= ohnd_d;
    otail_q    <= otail_d;
    one_q      <= one_d;
    odup_q     <= odup_d;
    ocor_q     <= ocor_d;
    odelay_q   <= odelay_d;
    omark_q    <= omark_d;
    olast_q    <= olast_d;
  end

  // Ports
  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = ov_q;
  assign kind_o          = okind_q;
  assign out_handle_o    = ohnd_q;
  assign out_tail_byte_o = otail_q;
  assign out_nonempty_o  = one_q;
  assign dup_flag_o      = odup_q;
  assign corrupt_flag_o  = ocor_q;
  assign delay_out_o     = odelay_q;
  assign reorder_mark_o  = omark_q;
  assign last_o          = olast_q;

`ifndef ASSERT_OFF
  // a reorder release always has the held packet behind it
  a_mark_has_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reorder_mark_o |-> held_valid_q && !last_o)
    else $error("reorder mark without held packet");

  // the held packet follows the first word of a release
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && reorder_mark_o |=>
      out_valid_o && last_o && !reorder_mark_o && !held_valid_q)
    else $error("held packet not released after reorder mark");

  // drop notice carries the handle but no other packet attributes
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DROP |->
      last_o && !reorder_mark_o && delay_out_o == '0 && !corrupt_flag_o)
    else $error("malformed drop notice");

  // delay never exceeds the ceiling
  a_delay_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> delay_out_o <= MAX_DELAY_MILLIS)
    else $error("delay above ceiling");
`endif

endmodule
